### src/lnt_pkg.sv
// ============================================================================
// lnt_pkg
// Types and constants shared by the peer record table.
// ============================================================================
`default_nettype none

package lnt_pkg;

    localparam int NAME_BYTES = 8;
    localparam int NAME_W     = 8 * NAME_BYTES;
    localparam int NLEN_W     = 4;
    localparam int STAMP_W    = 32;

    localparam logic CMD_UPSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic [31:0]        station;
        logic signed [15:0] signal;
        logic signed [7:0]  snr;
        logic [7:0]         hops;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic [15:0]        battery;
        logic [NAME_W-1:0]  name;
        logic [NLEN_W-1:0]  name_len;
    } rec_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_FETCH = 5'b00100,
        S_LOAD  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

### src/lnt_ram.sv
// ============================================================================
// lnt_ram
// Simple dual-port RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module lnt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/lru_node_table_top.sv
// ============================================================================
// lru_node_table_top
// Peer record table with least-recently-touched replacement.
// ============================================================================
// Input channel (in_valid/in_stall) takes one transaction at a time: an
// upsert (cmd 0) or a read by recency rank (cmd 1). Each transaction gives
// exactly one transaction on the output channel (out_valid/out_stall).
// Records and touch stamps sit in RAMs with a registered read port; valid
// bits sit in flops. An upsert walks all TABLE_ENTRIES slots once to find a
// match, a free slot or the oldest stamp. A read walks the stamp RAM once
// per rank; a rank at or beyond the occupied count misses without a walk,
// and an upsert with ID zero is answered without one.
// The walk through the stamp RAM sets the rate.
// Reset clears all valid bits, the touch clock and the change counter.
// A finished transaction waits in the output register; while it is stalled
// the next input transaction is still taken, and its result holds until the
// output register frees.
// ============================================================================
`default_nettype none

module lru_node_table_top #(
    parameter int TABLE_ENTRIES  = 16,
    parameter int NAME_MAX_BYTES = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 cmd,
    input  wire logic [31:0]                          station_id,
    input  wire logic signed [15:0]                   signal_strength,
    input  wire logic signed [7:0]                    snr_quarter_db,
    input  wire logic [7:0]                           hop_count,
    input  wire logic signed [31:0]                   latitude,
    input  wire logic signed [31:0]                   longitude,
    input  wire logic [15:0]                          battery_millivolts,
    input  wire logic [63:0]                          name_bytes,
    input  wire logic [7:0]                           name_length,
    input  wire logic                                 name_present,
    input  wire logic [7:0]                           recency_rank,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      hit,
    output logic [31:0]                               got_station,
    output logic signed [15:0]                        got_signal,
    output logic signed [7:0]                         got_snr,
    output logic [7:0]                                got_hops,
    output logic signed [31:0]                        got_latitude,
    output logic signed [31:0]                        got_longitude,
    output logic [15:0]                               got_battery,
    output logic [63:0]                               got_name,
    output logic [3:0]                                got_name_length,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]        occupied_count,
    output logic [31:0]                               change_counter
);

    localparam int IW   = $clog2(TABLE_ENTRIES);
    localparam int CW   = IW + 1;
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam int RECW = $bits(lnt_pkg::rec_t);

    lnt_pkg::state_t state_reg, state_next;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CNTW-1:0]          count_reg, count_next;
    logic [31:0]              clock_reg, clock_next;
    logic [31:0]              changes_reg, changes_next;

    logic                     cmd_reg;
    lnt_pkg::rec_t            item_reg;
    logic [7:0]               name_len_reg;
    logic                     name_present_reg;
    logic [7:0]               rank_reg;

    logic [CW-1:0]            issue_reg, issue_next;
    logic                     pend_vld_reg, pend_vld_next;
    logic [IW-1:0]            pend_idx_reg, pend_idx_next;
    logic                     match_reg, match_next;
    logic [IW-1:0]            match_idx_reg, match_idx_next;
    logic                     free_reg, free_next;
    logic [IW-1:0]            free_idx_reg, free_idx_next;
    logic                     have_reg, have_next;
    logic [31:0]              best_reg, best_next;
    logic [IW-1:0]            best_idx_reg, best_idx_next;
    logic                     bounded_reg, bounded_next;
    logic [31:0]              bound_reg, bound_next;
    logic [7:0]               pass_reg, pass_next;
    logic [IW-1:0]            slot_reg, slot_next;
    logic                     slot_old_reg, slot_old_next;
    logic                     hit_reg, hit_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     o_hit_reg;
    lnt_pkg::rec_t            o_rec_reg;

    logic                     rd_en;
    logic [IW-1:0]            rd_addr;
    logic                     wr_en;
    logic [RECW-1:0]          rec_rd_raw;
    lnt_pkg::rec_t            rec_rd;
    lnt_pkg::rec_t            rec_wr;
    logic [31:0]              stamp_rd;
    logic                     load_out;

    logic                     e_valid;
    logic                     scan_last;
    logic [lnt_pkg::NLEN_W-1:0] clen;
    logic [63:0]              old_name;

    assign rec_rd = lnt_pkg::rec_t'(rec_rd_raw);

    lnt_ram #(
        .WIDTH (RECW),
        .DEPTH (TABLE_ENTRIES)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (rec_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rec_rd_raw)
    );

    lnt_ram #(
        .WIDTH (lnt_pkg::STAMP_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_stamp_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (clock_reg + 32'd1),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (stamp_rd)
    );

    assign in_stall = (state_reg != lnt_pkg::S_IDLE);
    assign e_valid  = valid_reg[pend_idx_reg];
    assign scan_last = pend_vld_reg && (pend_idx_reg == IW'(TABLE_ENTRIES - 1));
    assign clen = (name_len_reg > 8'(NAME_MAX_BYTES)) ?
                  lnt_pkg::NLEN_W'(NAME_MAX_BYTES) : name_len_reg[lnt_pkg::NLEN_W-1:0];
    assign old_name = slot_old_reg ? rec_rd.name : 64'd0;
    assign load_out = (state_reg == lnt_pkg::S_RESP) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        rec_wr          = item_reg;
        rec_wr.name_len = clen;
        rec_wr.name     = old_name;
        for (int b = 0; b < lnt_pkg::NAME_BYTES; b++)
        begin
            if (name_present_reg && (b < int'(clen)))
            begin
                rec_wr.name[8*b +: 8] = item_reg.name[8*b +: 8];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        clock_next     = clock_reg;
        changes_next   = changes_reg;
        issue_next     = issue_reg;
        pend_vld_next  = 1'b0;
        pend_idx_next  = pend_idx_reg;
        match_next     = match_reg;
        match_idx_next = match_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        bounded_next   = bounded_reg;
        bound_next     = bound_reg;
        pass_next      = pass_reg;
        slot_next      = slot_reg;
        slot_old_next  = slot_old_reg;
        hit_next       = hit_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[IW-1:0];
        wr_en          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            lnt_pkg::S_IDLE:
            begin
                issue_next   = '0;
                match_next   = 1'b0;
                free_next    = 1'b0;
                have_next    = 1'b0;
                bounded_next = 1'b0;
                pass_next    = '0;
                hit_next     = 1'b0;
                if (in_valid)
                begin
                    if (cmd == lnt_pkg::CMD_UPSERT)
                    begin
                        state_next = (station_id == 32'd0) ? lnt_pkg::S_RESP : lnt_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = (32'(recency_rank) >= 32'(count_reg)) ?
                                     lnt_pkg::S_RESP : lnt_pkg::S_SCAN;
                    end
                end
            end

            lnt_pkg::S_SCAN:
            begin
                if (issue_reg < CW'(TABLE_ENTRIES))
                begin
                    rd_en         = 1'b1;
                    issue_next    = issue_reg + CW'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = issue_reg[IW-1:0];
                end
                if (pend_vld_reg)
                begin
                    if (cmd_reg == lnt_pkg::CMD_UPSERT)
                    begin
                        if (e_valid && !match_reg && rec_rd.station == item_reg.station)
                        begin
                            match_next     = 1'b1;
                            match_idx_next = pend_idx_reg;
                        end
                        if (!e_valid && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = pend_idx_reg;
                        end
                        if (!have_reg || stamp_rd < best_reg)
                        begin
                            have_next     = 1'b1;
                            best_next     = stamp_rd;
                            best_idx_next = pend_idx_reg;
                        end
                    end
                    else if (e_valid && (!bounded_reg || stamp_rd < bound_reg)
                             && (!have_reg || stamp_rd >= best_reg))
                    begin
                        have_next     = 1'b1;
                        best_next     = stamp_rd;
                        best_idx_next = pend_idx_reg;
                    end
                end
                if (scan_last)
                begin
                    if (cmd_reg == lnt_pkg::CMD_UPSERT)
                    begin
                        slot_next     = match_next ? match_idx_next :
                                        (free_next ? free_idx_next : best_idx_next);
                        slot_old_next = match_next || !free_next;
                        state_next    = lnt_pkg::S_FETCH;
                    end
                    else if (!have_next)
                    begin
                        hit_next   = 1'b0;
                        state_next = lnt_pkg::S_RESP;
                    end
                    else if (pass_reg == rank_reg)
                    begin
                        hit_next   = 1'b1;
                        slot_next  = best_idx_next;
                        state_next = lnt_pkg::S_FETCH;
                    end
                    else
                    begin
                        bound_next   = best_next;
                        bounded_next = 1'b1;
                        have_next    = 1'b0;
                        pass_next    = pass_reg + 8'd1;
                        issue_next   = '0;
                    end
                end
            end

            lnt_pkg::S_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = slot_reg;
                state_next = lnt_pkg::S_LOAD;
            end

            lnt_pkg::S_LOAD:
            begin
                if (cmd_reg == lnt_pkg::CMD_UPSERT)
                begin
                    wr_en               = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    if (!slot_old_reg)
                    begin
                        count_next = count_reg + CNTW'(1);
                    end
                    clock_next   = clock_reg + 32'd1;
                    changes_next = changes_reg + 32'd1;
                end
                state_next = lnt_pkg::S_RESP;
            end

            lnt_pkg::S_RESP:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = lnt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = lnt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lnt_pkg::S_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            clock_reg     <= '0;
            changes_reg   <= '0;
            out_valid_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            clock_reg     <= clock_next;
            changes_reg   <= changes_next;
            out_valid_reg <= out_valid_next;
            pend_vld_reg  <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg     <= issue_next;
        pend_idx_reg  <= pend_idx_next;
        match_reg     <= match_next;
        match_idx_reg <= match_idx_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        have_reg      <= have_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        bounded_reg   <= bounded_next;
        bound_reg     <= bound_next;
        pass_reg      <= pass_next;
        slot_reg      <= slot_next;
        slot_old_reg  <= slot_old_next;
        hit_reg       <= hit_next;
        if (state_reg == lnt_pkg::S_IDLE && in_valid)
        begin
            cmd_reg            <= cmd;
            item_reg.station   <= station_id;
            item_reg.signal    <= signal_strength;
            item_reg.snr       <= snr_quarter_db;
            item_reg.hops      <= hop_count;
            item_reg.latitude  <= latitude;
            item_reg.longitude <= longitude;
            item_reg.battery   <= battery_millivolts;
            item_reg.name      <= name_bytes;
            item_reg.name_len  <= '0;
            name_len_reg       <= name_length;
            name_present_reg   <= name_present;
            rank_reg           <= recency_rank;
        end
        if (load_out)
        begin
            o_hit_reg <= hit_reg;
            o_rec_reg <= hit_reg ? rec_rd : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = o_hit_reg;
    assign got_station     = o_rec_reg.station;
    assign got_signal      = o_rec_reg.signal;
    assign got_snr         = o_rec_reg.snr;
    assign got_hops        = o_rec_reg.hops;
    assign got_latitude    = o_rec_reg.latitude;
    assign got_longitude   = o_rec_reg.longitude;
    assign got_battery     = o_rec_reg.battery;
    assign got_name        = o_rec_reg.name;
    assign got_name_length = o_rec_reg.name_len;

    logic [CNTW-1:0] o_count_reg;
    logic [31:0]     o_changes_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_count_reg   <= count_reg;
            o_changes_reg <= changes_reg;
        end
    end

    assign occupied_count = o_count_reg;
    assign change_counter = o_changes_reg;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ============================================================================
// tb
// Self-checking bench for the peer record table with LRU replacement.
// A queue of upsert and read transactions feeds a clocked driver. Each
// accepted transaction goes through a local table model, which predicts the
// one result. A clocked monitor checks every result, field by field, against
// the oldest prediction. Both channels idle at random in phases, the output
// is held off for a long stretch, and the input pauses until the results
// drain.
// ============================================================================
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES      = 16;
    localparam int RAND_ITEMS   = 1430;
    localparam int WD_LIMIT     = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 1100;
    localparam int ID_POOL      = 24;

    typedef struct {
        logic               cmd;
        logic [31:0]        id;
        logic signed [15:0] sig;
        logic signed [7:0]  snr;
        logic [7:0]         hops;
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic [15:0]        batt;
        logic [63:0]        name;
        logic [7:0]         nlen;
        logic               npres;
        logic [7:0]         rank;
        logic               drain;
    } peer_txn_t;

    typedef struct {
        logic               hit;
        logic [31:0]        station;
        logic signed [15:0] sig;
        logic signed [7:0]  snr;
        logic [7:0]         hops;
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic [15:0]        batt;
        logic [63:0]        name;
        logic [3:0]         nlen;
        logic [4:0]         count;
        logic [31:0]        changes;
    } peer_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    peer_txn_t cur = '{default: '0};

    logic               in_stall;
    logic               out_valid;
    logic               hit;
    logic [31:0]        got_station;
    logic signed [15:0] got_signal;
    logic signed [7:0]  got_snr;
    logic [7:0]         got_hops;
    logic signed [31:0] got_latitude;
    logic signed [31:0] got_longitude;
    logic [15:0]        got_battery;
    logic [63:0]        got_name;
    logic [3:0]         got_name_length;
    logic [4:0]         occupied_count;
    logic [31:0]        change_counter;

    lru_node_table_top u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .cmd                (cur.cmd),
        .station_id         (cur.id),
        .signal_strength    (cur.sig),
        .snr_quarter_db     (cur.snr),
        .hop_count          (cur.hops),
        .latitude           (cur.lat),
        .longitude          (cur.lon),
        .battery_millivolts (cur.batt),
        .name_bytes         (cur.name),
        .name_length        (cur.nlen),
        .name_present       (cur.npres),
        .recency_rank       (cur.rank),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .hit                (hit),
        .got_station        (got_station),
        .got_signal         (got_signal),
        .got_snr            (got_snr),
        .got_hops           (got_hops),
        .got_latitude       (got_latitude),
        .got_longitude      (got_longitude),
        .got_battery        (got_battery),
        .got_name           (got_name),
        .got_name_length    (got_name_length),
        .occupied_count     (occupied_count),
        .change_counter     (change_counter)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // table model
    logic               tv_valid [ENTRIES];
    logic [31:0]        tv_station [ENTRIES];
    logic signed [15:0] tv_sig [ENTRIES];
    logic signed [7:0]  tv_snr [ENTRIES];
    logic [7:0]         tv_hops [ENTRIES];
    logic signed [31:0] tv_lat [ENTRIES];
    logic signed [31:0] tv_lon [ENTRIES];
    logic [15:0]        tv_batt [ENTRIES];
    logic [63:0]        tv_name [ENTRIES];
    logic [3:0]         tv_nlen [ENTRIES];
    logic [31:0]        tv_stamp [ENTRIES];
    logic [31:0]        touch_clk = '0;
    logic [31:0]        upsert_cnt = '0;

    peer_txn_t    txn_q [$];
    peer_result_t result_q [$];

    int n_upserts = 0;
    int n_reads   = 0;
    int n_hits    = 0;
    int n_evicts  = 0;
    int n_errors  = 0;
    int n_acc     = 0;
    int n_out     = 0;

    function automatic int lookup_rank(logic [7:0] rank);
        logic [31:0] bound;
        logic [31:0] best;
        logic        bounded;
        int          sel;
        bound   = '0;
        bounded = 1'b0;
        sel     = -1;
        for (int p = 0; p <= rank; p++)
        begin
            best = '0;
            sel  = -1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (tv_valid[i] && !(bounded && tv_stamp[i] >= bound)
                    && (sel < 0 || tv_stamp[i] >= best))
                begin
                    best = tv_stamp[i];
                    sel  = i;
                end
            end
            if (sel < 0)
                return -1;
            bound   = best;
            bounded = 1'b1;
        end
        return sel;
    endfunction

    function automatic peer_result_t apply_peer_txn(peer_txn_t t);
        peer_result_t r;
        int           slot;
        int           len;
        logic [63:0]  m;
        r = '{default: '0};
        if (t.cmd == lnt_pkg::CMD_UPSERT)
        begin
            n_upserts++;
            if (t.id != 0)
            begin
                slot = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && tv_valid[i] && tv_station[i] == t.id)
                        slot = i;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !tv_valid[i])
                        slot = i;
                if (slot < 0)
                begin
                    n_evicts++;
                    slot = 0;
                    for (int i = 1; i < ENTRIES; i++)
                        if (tv_stamp[i] < tv_stamp[slot])
                            slot = i;
                end
                len = (t.nlen > lnt_pkg::NAME_BYTES) ? lnt_pkg::NAME_BYTES : int'(t.nlen);
                tv_valid[slot]   = 1'b1;
                tv_station[slot] = t.id;
                tv_sig[slot]     = t.sig;
                tv_snr[slot]     = t.snr;
                tv_hops[slot]    = t.hops;
                tv_lat[slot]     = t.lat;
                tv_lon[slot]     = t.lon;
                tv_batt[slot]    = t.batt;
                tv_nlen[slot]    = len[3:0];
                if (t.npres && len > 0)
                begin
                    m = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
                    tv_name[slot] = (tv_name[slot] & ~m) | (t.name & m);
                end
                touch_clk      = touch_clk + 32'd1;
                tv_stamp[slot] = touch_clk;
                upsert_cnt     = upsert_cnt + 32'd1;
            end
        end
        else
        begin
            n_reads++;
            slot = lookup_rank(t.rank);
            if (slot >= 0)
            begin
                n_hits++;
                r.hit     = 1'b1;
                r.station = tv_station[slot];
                r.sig     = tv_sig[slot];
                r.snr     = tv_snr[slot];
                r.hops    = tv_hops[slot];
                r.lat     = tv_lat[slot];
                r.lon     = tv_lon[slot];
                r.batt    = tv_batt[slot];
                r.name    = tv_name[slot];
                r.nlen    = tv_nlen[slot];
            end
        end
        for (int i = 0; i < ENTRIES; i++)
            r.count += 5'(tv_valid[i]);
        r.changes = upsert_cnt;
        return r;
    endfunction

    function automatic peer_txn_t rand_txn();
        peer_txn_t t;
        t.cmd   = 1'($urandom_range(1));
        t.id    = $urandom;
        t.sig   = 16'($urandom);
        t.snr   = 8'($urandom);
        t.hops  = 8'($urandom);
        t.lat   = $urandom;
        t.lon   = $urandom;
        t.batt  = 16'($urandom);
        t.name  = {$urandom, $urandom};
        t.nlen  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(9));
        t.npres = 1'($urandom_range(1));
        t.rank  = 8'($urandom);
        t.drain = 1'b0;
        return t;
    endfunction

    function automatic peer_txn_t upsert_txn(logic [31:0] id);
        peer_txn_t t;
        t     = rand_txn();
        t.cmd = lnt_pkg::CMD_UPSERT;
        t.id  = id;
        return t;
    endfunction

    function automatic peer_txn_t read_txn(logic [7:0] rank);
        peer_txn_t t;
        t      = rand_txn();
        t.cmd  = lnt_pkg::CMD_READ;
        t.rank = rank;
        return t;
    endfunction

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", fname, want, got);
            n_errors++;
        end
    endtask

    function automatic int send_idle_pct();
        return (n_acc < 480) ? 16 : (n_acc < 960) ? 83 : 0;
    endfunction

    function automatic int recv_idle_pct();
        return (n_acc < 480) ? 83 : (n_acc < 960) ? 16 : 0;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                result_q.push_back(apply_peer_txn(cur));
                n_acc <= n_acc + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (txn_q.size() > 0 && !(txn_q[0].drain && result_q.size() > 0)
                    && $urandom_range(99) >= send_idle_pct())
                begin
                    cur      <= txn_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and output stall
    int   hold_cnt  = 0;
    logic hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        peer_result_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_out <= n_out + 1;
                if (result_q.size() == 0)
                begin
                    $error("result with no transaction pending");
                    n_errors++;
                end
                else
                begin
                    e = result_q.pop_front();
                    check_field("hit", 64'(e.hit), 64'(hit));
                    check_field("got_station", 64'(e.station), 64'(got_station));
                    check_field("got_signal", 64'(unsigned'(e.sig)), 64'(unsigned'(got_signal)));
                    check_field("got_snr", 64'(unsigned'(e.snr)), 64'(unsigned'(got_snr)));
                    check_field("got_hops", 64'(e.hops), 64'(got_hops));
                    check_field("got_latitude", 64'(unsigned'(e.lat)),
                                64'(unsigned'(got_latitude)));
                    check_field("got_longitude", 64'(unsigned'(e.lon)),
                                64'(unsigned'(got_longitude)));
                    check_field("got_battery", 64'(e.batt), 64'(got_battery));
                    check_field("got_name", e.name, got_name);
                    check_field("got_name_length", 64'(e.nlen), 64'(got_name_length));
                    check_field("occupied_count", 64'(e.count), 64'(occupied_count));
                    check_field("change_counter", 64'(e.changes), 64'(change_counter));
                end
            end
            if (!hold_done && n_acc >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_cnt  <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt  <= hold_cnt - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct());
            end
        end
    end

    // watchdog
    int stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WD_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", WD_LIMIT);
                $display("lru_node_table_top test failed");
                $finish;
            end
        end
    end

    initial
    begin
        peer_txn_t t;
        int        r;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tv_valid[i] = 1'b0;
            tv_station[i] = '0;
            tv_sig[i] = '0;
            tv_snr[i] = '0;
            tv_hops[i] = '0;
            tv_lat[i] = '0;
            tv_lon[i] = '0;
            tv_batt[i] = '0;
            tv_name[i] = '0;
            tv_nlen[i] = '0;
            tv_stamp[i] = '0;
        end

        txn_q.push_back(read_txn(8'd0));
        txn_q.push_back(upsert_txn(32'd0));
        t = upsert_txn(32'hFFFF_FFFF);
        t.sig = 16'sh7FFF; t.snr = 8'sh7F; t.hops = 8'hFF;
        t.lat = 32'sh7FFF_FFFF; t.lon = 32'sh7FFF_FFFF; t.batt = 16'hFFFF;
        t.name = '1; t.nlen = 8'hFF; t.npres = 1'b1;
        txn_q.push_back(t);
        t = upsert_txn(32'd1);
        t.sig = 16'sh8000; t.snr = 8'sh80; t.hops = 8'h00;
        t.lat = 32'sh8000_0000; t.lon = 32'sh8000_0000; t.batt = 16'h0000;
        t.nlen = 8'd0; t.npres = 1'b1;
        txn_q.push_back(t);
        t = upsert_txn(32'd1);
        t.name = 64'h8877_6655_4433_2211; t.nlen = 8'd8; t.npres = 1'b1;
        txn_q.push_back(t);
        t = upsert_txn(32'd1);
        t.name = 64'hA5A5_A5A5_A5A5_A5A5; t.nlen = 8'd3; t.npres = 1'b1;
        txn_q.push_back(t);
        t = upsert_txn(32'd2);
        t.nlen = 8'd9; t.npres = 1'b0;
        txn_q.push_back(t);
        t = upsert_txn(32'hFFFF_FFFF);
        t.nlen = 8'd5; t.npres = 1'b0;
        txn_q.push_back(t);
        txn_q.push_back(read_txn(8'd0));
        txn_q.push_back(read_txn(8'd1));
        txn_q.push_back(read_txn(8'd2));
        txn_q.push_back(read_txn(8'd3));
        txn_q.push_back(read_txn(8'd255));
        t = upsert_txn(32'd0);
        t.drain = 1'b1;
        txn_q.push_back(t);
        txn_q.push_back(read_txn(8'd0));

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                t = rand_txn();
            else if (r < 8)
                t = upsert_txn(32'd0);
            else if (r < 58)
                t = upsert_txn(32'($urandom_range(1, ID_POOL)) * 32'h9E37_79B1);
            else if (r < 90)
                t = read_txn(8'($urandom_range(0, ENTRIES + 1)));
            else
                t = read_txn(8'($urandom));
            t.drain = (n == 700 || n == 1300);
            txn_q.push_back(t);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (txn_q.size() > 0 || in_valid || result_q.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (result_q.size() > 0)
        begin
            $error("%0d results never arrived", result_q.size());
            n_errors++;
        end

        $display("covered %0d upserts (%0d evictions) and %0d reads (%0d hits), %0d results",
                 n_upserts, n_evicts, n_reads, n_hits, n_out);
        if (n_errors == 0)
            $display("lru_node_table_top test passed");
        else
            $display("lru_node_table_top test failed");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
src/lnt_pkg.sv
src/lnt_ram.sv
src/lru_node_table_top.sv
tb/sv/tb.sv
